[design/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned LIMIT_W             = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd12288;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // One decoded input transaction: up to three bytes, or a bare end marker
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] cnt;    // results to send, 1 to 3
    logic       data;   // 0 for a bare end marker
    logic       last;
  } jsu_entry_t;

endpackage

[design/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Accepts input bytes, tracks escape state and decodes the bytes into
// queue entries of up to three output bytes. Holds the output limit register.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [7:0]               in_byte,
  input  logic                     is_last,
  input  logic                     cfg_write,
  input  logic [jsu_pkg::LIMIT_W-1:0] cfg_limit,
  input  logic                     q_full,
  output logic                     accept,
  output logic                     push,
  output jsu_pkg::jsu_entry_t      push_entry
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [2:0] HEX_FINAL = 3'd4;

  logic [LIMIT_W-1:0] limit;
  logic               esc, esc_next;
  logic [2:0]         hcnt, hcnt_next;
  logic [15:0]        hval, hval_next;
  logic               hbad, hbad_next;
  logic [LIMIT_W-1:0] emitted, emitted_next;

  logic               is_hex;
  logic [3:0]         nib;
  logic [15:0]        cp;
  logic [1:0]         n;
  logic [7:0]         b0, b1, b2;
  logic [LIMIT_W:0]   sum;

  assign accept = in_valid && !q_full;

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      nib = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      nib = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      nib = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    esc_next  = esc;
    hcnt_next = hcnt;
    hval_next = hval;
    hbad_next = hbad;
    n         = 2'd0;
    b0        = 8'd0;
    b1        = 8'd0;
    b2        = 8'd0;
    cp        = is_hex ? {hval[11:0], nib} : hval;

    if (hcnt != 3'd0) begin
      if (hcnt == HEX_FINAL) begin
        if (!(hbad || !is_hex)) begin
          if (cp <= 16'h007F) begin
            n  = 2'd1;
            b0 = cp[7:0];
          end else if (cp <= 16'h07FF) begin
            n  = 2'd2;
            b0 = 8'hC0 | {3'b000, cp[10:6]};
            b1 = 8'h80 | {2'b00, cp[5:0]};
          end else begin
            n  = 2'd3;
            b0 = 8'hE0 | {4'h0, cp[15:12]};
            b1 = 8'h80 | {2'b00, cp[11:6]};
            b2 = 8'h80 | {2'b00, cp[5:0]};
          end
        end
        hcnt_next = 3'd0;
        hval_next = 16'd0;
        hbad_next = 1'b0;
      end else begin
        hcnt_next = hcnt + 3'd1;
        hval_next = cp;
        hbad_next = hbad || !is_hex;
      end
    end else if (esc) begin
      esc_next = 1'b0;
      if (in_byte == CH_U) begin
        hcnt_next = 3'd1;
        hval_next = 16'd0;
        hbad_next = 1'b0;
      end else begin
        n = 2'd1;
        case (in_byte)
          CH_B:    b0 = 8'h08;
          CH_F:    b0 = 8'h0C;
          CH_N:    b0 = 8'h0A;
          CH_R:    b0 = 8'h0A;
          CH_T:    b0 = 8'h20;
          default: b0 = in_byte;
        endcase
      end
    end else if (emitted >= limit) begin
      n = 2'd0;
    end else if (in_byte == CH_BSLASH && !is_last) begin
      esc_next = 1'b1;
    end else begin
      n  = 2'd1;
      b0 = in_byte;
    end

    sum          = {1'b0, emitted} + {{(LIMIT_W-1){1'b0}}, n};
    emitted_next = sum[LIMIT_W] ? {LIMIT_W{1'b1}} : sum[LIMIT_W-1:0];

    if (is_last) begin
      esc_next     = 1'b0;
      hcnt_next    = 3'd0;
      hval_next    = 16'd0;
      hbad_next    = 1'b0;
      emitted_next = '0;
    end
  end

  assign push             = accept && (n != 2'd0 || is_last);
  assign push_entry.byte0 = b0;
  assign push_entry.byte1 = b1;
  assign push_entry.byte2 = b2;
  assign push_entry.cnt   = (n == 2'd0) ? 2'd1 : n;
  assign push_entry.data  = (n != 2'd0);
  assign push_entry.last  = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= LIMIT_RESET;
      esc     <= 1'b0;
      hcnt    <= 3'd0;
      hval    <= 16'd0;
      hbad    <= 1'b0;
      emitted <= '0;
    end else begin
      if (cfg_write) begin
        limit <= cfg_limit;
      end
      if (accept) begin
        esc     <= esc_next;
        hcnt    <= hcnt_next;
        hval    <= hval_next;
        hbad    <= hbad_next;
        emitted <= emitted_next;
      end
    end
  end

endmodule

[design/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Small FIFO of decoded entries between the front and back ends.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jsu_pkg::jsu_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output jsu_pkg::jsu_entry_t head
);
  import jsu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  jsu_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_MAX);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[design/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Serialises queued entries into single-byte output transactions through
// an output register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  jsu_pkg::jsu_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic                run_last,
  output logic                string_end
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       fin;
  logic [7:0] sel;

  assign load = !out_valid || !out_stall;
  assign fin  = (idx == head.cnt - 2'd1);
  assign pop  = load && head_valid && fin;

  always_comb begin
    case (idx)
      2'd0:    sel = head.byte0;
      2'd1:    sel = head.byte1;
      default: sel = head.byte2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= fin ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte   <= sel;
      has_byte   <= head.data;
      run_last   <= fin;
      string_end <= fin && head.last;
    end
  end

endmodule

[design/json_string_unescape_utf8.sv]
// Path: an input transaction passes through the queue, then the output register.
// Throughput: one input byte per cycle while the queue is not full; a \u escape of
//   two or three UTF-8 bytes becomes that many output bytes, absorbed by the queue.
// Reset: synchronous, clears escape state, byte count, queue and output;
//   the limit returns to 12288.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper with UTF-8 output of \u escapes.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [jsu_pkg::LIMIT_W-1:0] max_output_bytes,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        has_byte,
  output logic                        run_last,
  output logic                        string_end
);
  import jsu_pkg::*;

  logic       accept, push, pop, q_full, q_not_empty;
  jsu_entry_t push_entry, head;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .is_last    (is_last),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_limit  (max_output_bytes),
    .q_full     (q_full),
    .accept     (accept),
    .push       (push),
    .push_entry (push_entry)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push && accept),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

[design/jsu_checker.sv]
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       run_last,
  input logic       string_end
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string end without run last");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> run_last && string_end && out_byte == 8'd0)
    else $error("malformed bare end marker");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(has_byte)
      && $stable(run_last) && $stable(string_end))
    else $error("stalled output transaction changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .has_byte   (has_byte),
  .run_last   (run_last),
  .string_end (string_end)
);
